[sv/lsi_pkg.sv]
package lsi_pkg;

    // mode codes
    localparam logic [1:0] MODE_SAFE    = 2'd0;
    localparam logic [1:0] MODE_ARMING  = 2'd1;
    localparam logic [1:0] MODE_ARMED   = 2'd2;
    localparam logic [1:0] MODE_TRIPPED = 2'd3;

    // event kinds
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_PACKET = 2'd1;
    localparam logic [1:0] OP_DISARM = 2'd2;

    // configuration register indexes
    localparam logic CFG_N_MAX        = 1'b0;
    localparam logic CFG_CHAL_PERIOD  = 1'b1;

    // configuration reset values
    localparam logic [3:0]  N_MAX_RESET       = 4'd10;
    localparam logic [15:0] CHAL_PERIOD_RESET = 16'd1000;

    // stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    localparam int WIN_W = 25;
    localparam logic [WIN_W-1:0] MS_PER_SECOND = 25'd1000;

    typedef struct packed {
        logic [3:0]  n_max;
        logic [15:0] challenge_period_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic        packet_ok;
        logic [7:0]  resp_exponent;
        logic        grant_valid;
        logic        bit_pass;
        logic        relay_sense;
        logic        challenge_ok;
    } event_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic             relay_drive;
        logic             relay_write;
        logic             watchdog_start;
        logic [WIN_W-1:0] watchdog_window_ms;
        logic             challenge_send;
        logic [3:0]       status_nibble;
        logic [WIN_W-1:0] lease_remaining_ms;
        logic             clear_nonces;
    } result_t;

    // lease window of 2^n seconds in milliseconds
    function automatic logic [WIN_W-1:0] lease_window(input logic [3:0] n);
        lease_window = MS_PER_SECOND << n;
    endfunction

endpackage

[sv/lsi_cfg.sv]
module lsi_cfg
    import lsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.n_max               <= N_MAX_RESET;
            cfg_reg.challenge_period_ms <= CHAL_PERIOD_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_N_MAX:       cfg_reg.n_max <= wr_data[3:0];
                CFG_CHAL_PERIOD: cfg_reg.challenge_period_ms <= wr_data[15:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/lsi_step.sv]
module lsi_step
    import lsi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  event_t  ev,
    input  cfg_t    cfg,
    output result_t res
);

    logic [1:0]  mode_reg, mode_next;
    logic        relay_reg, relay_next;
    logic [3:0]  act_exp_reg, act_exp_next;
    logic [31:0] expiry_reg, expiry_next;
    logic [31:0] chal_time_reg, chal_time_next;
    logic        grant_reg, grant_next;
    logic [3:0]  pend_exp_reg, pend_exp_next;
    logic        disarm_reg, disarm_next;

    logic [WIN_W-1:0] window;
    logic [32:0]      arm_sum;
    logic [31:0]      old_diff;
    logic [31:0]      chal_sum;
    logic             chal_due;
    logic             lease_over;
    logic             did_arm;
    logic             o_write;
    logic             o_chal;
    logic             o_clear;

    // shared arithmetic
    assign window     = lease_window(pend_exp_reg);
    assign arm_sum    = {1'b0, ev.now_ms} + {8'd0, window};
    assign old_diff   = expiry_reg - ev.now_ms;
    assign chal_sum   = ev.now_ms + {16'd0, cfg.challenge_period_ms};
    assign chal_due   = (ev.now_ms >= chal_time_reg) && ev.challenge_ok;
    assign lease_over = ev.now_ms >= expiry_reg;

    // event handling
    always_comb
    begin
        mode_next      = mode_reg;
        relay_next     = relay_reg;
        act_exp_next   = act_exp_reg;
        expiry_next    = expiry_reg;
        chal_time_next = chal_time_reg;
        grant_next     = grant_reg;
        pend_exp_next  = pend_exp_reg;
        disarm_next    = disarm_reg;
        did_arm        = 1'b0;
        o_write        = 1'b0;
        o_chal         = 1'b0;
        o_clear        = 1'b0;

        case (ev.opcode)
            OP_PACKET:
            begin
                if (ev.packet_ok && (mode_reg == MODE_SAFE || mode_reg == MODE_ARMED))
                begin
                    if (ev.resp_exponent == 8'd0)
                        disarm_next = 1'b1;
                    else if (ev.resp_exponent <= {4'd0, cfg.n_max} && ev.grant_valid)
                    begin
                        pend_exp_next = ev.resp_exponent[3:0];
                        grant_next    = 1'b1;
                    end
                end
            end
            OP_DISARM:
                disarm_next = 1'b1;
            OP_TICK:
            begin
                if (disarm_reg)
                begin
                    // back to safe
                    mode_next   = MODE_SAFE;
                    relay_next  = 1'b0;
                    o_write     = 1'b1;
                    o_clear     = 1'b1;
                    grant_next  = 1'b0;
                    disarm_next = 1'b0;
                end
                else
                begin
                    case (mode_reg)
                        MODE_SAFE:
                        begin
                            if (chal_due)
                            begin
                                o_chal         = 1'b1;
                                chal_time_next = chal_sum;
                            end
                            if (grant_reg)
                                mode_next = MODE_ARMING;
                        end
                        MODE_ARMING:
                        begin
                            o_write    = 1'b1;
                            grant_next = 1'b0;
                            if (ev.bit_pass)
                                did_arm = 1'b1;
                            else
                            begin
                                mode_next  = MODE_TRIPPED;
                                relay_next = 1'b0;
                            end
                        end
                        MODE_ARMED:
                        begin
                            if (chal_due)
                            begin
                                o_chal         = 1'b1;
                                chal_time_next = chal_sum;
                            end
                            if (grant_reg)
                            begin
                                grant_next = 1'b0;
                                did_arm    = 1'b1;
                                o_write    = 1'b1;
                            end
                            else if (lease_over)
                            begin
                                mode_next   = MODE_SAFE;
                                relay_next  = 1'b0;
                                o_write     = 1'b1;
                                o_clear     = 1'b1;
                                grant_next  = 1'b0;
                                disarm_next = 1'b0;
                            end
                            else if (ev.relay_sense != relay_reg)
                            begin
                                mode_next  = MODE_TRIPPED;
                                relay_next = 1'b0;
                                o_write    = 1'b1;
                            end
                        end
                        default:
                        begin
                            // tripped: keep commanding the relay open
                            relay_next = 1'b0;
                            o_write    = 1'b1;
                        end
                    endcase
                end
            end
            default: ;
        endcase

        // lease grant or refresh
        if (did_arm)
        begin
            act_exp_next = pend_exp_reg;
            expiry_next  = arm_sum[31:0];
            mode_next    = MODE_ARMED;
            relay_next   = 1'b1;
        end
    end

    // result fields
    always_comb
    begin
        res.mode               = mode_next;
        res.relay_drive        = relay_next;
        res.relay_write        = o_write;
        res.watchdog_start     = did_arm;
        res.watchdog_window_ms = did_arm ? window : '0;
        res.challenge_send     = o_chal;
        res.status_nibble      = (mode_next == MODE_ARMED) ? act_exp_next : 4'd0;
        res.clear_nonces       = o_clear;
        if (did_arm)
            res.lease_remaining_ms = arm_sum[32] ? '0 : window;
        else if (mode_next == MODE_ARMED && !lease_over)
            res.lease_remaining_ms = old_diff[WIN_W-1:0];
        else
            res.lease_remaining_ms = '0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SAFE;
            relay_reg     <= 1'b0;
            act_exp_reg   <= 4'd0;
            expiry_reg    <= 32'd0;
            chal_time_reg <= 32'd0;
            grant_reg     <= 1'b0;
            pend_exp_reg  <= 4'd0;
            disarm_reg    <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            relay_reg     <= relay_next;
            act_exp_reg   <= act_exp_next;
            expiry_reg    <= expiry_next;
            chal_time_reg <= chal_time_next;
            grant_reg     <= grant_next;
            pend_exp_reg  <= pend_exp_next;
            disarm_reg    <= disarm_next;
        end
    end

endmodule

[sv/lease_safety_interlock.sv]
// channel   | signals                                  | beat carries
// s_axis    | s_tvalid s_tready s_tuser s_tdata        | one event
// m_axis    | m_tvalid m_tready m_tdata                | one result per event
// cfg       | cfg_valid cfg_ready cfg_index cfg_data   | one register write
//
// one event per clock sustained while m_tready stays high; an input beat reaches the result beat
// through the input register, then step logic and state update into the result register
// rst_n asserted clears mode, lease, challenge timer and pending flags
// a stalled result holds in the result register; the input register still takes
// one more beat if it is empty, then s_tready drops until m_tready returns
// cfg_ready is always high
module lease_safety_interlock
    import lsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode[1:0]
    input  logic [1:0]            s_tuser,
    // now_ms[31:0] packet_ok[32] resp_exponent[40:33] grant_valid[41]
    // bit_pass[42] relay_sense[43] challenge_ok[44], zero pad above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mode[1:0] relay_drive[2] relay_write[3] watchdog_start[4]
    // watchdog_window_ms[29:5] challenge_send[30] status_nibble[34:31]
    // lease_remaining_ms[59:35] clear_nonces[60], zero pad above
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data
);

    logic    in_valid_reg;
    event_t  in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    cfg_t    cfg;
    logic    advance;
    logic    fire;

    // handshake
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    lsi_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.opcode        <= s_tuser;
            in_item_reg.now_ms        <= s_tdata[31:0];
            in_item_reg.packet_ok     <= s_tdata[32];
            in_item_reg.resp_exponent <= s_tdata[40:33];
            in_item_reg.grant_valid   <= s_tdata[41];
            in_item_reg.bit_pass      <= s_tdata[42];
            in_item_reg.relay_sense   <= s_tdata[43];
            in_item_reg.challenge_ok  <= s_tdata[44];
        end
    end

    lsi_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ev    (in_item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_res_reg <= step_res;
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0,
                       out_res_reg.clear_nonces,
                       out_res_reg.lease_remaining_ms,
                       out_res_reg.status_nibble,
                       out_res_reg.challenge_send,
                       out_res_reg.watchdog_window_ms,
                       out_res_reg.watchdog_start,
                       out_res_reg.relay_write,
                       out_res_reg.relay_drive,
                       out_res_reg.mode};

endmodule

[sv/lsi_checker.sv]
module lsi_checker
    import lsi_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // relay only closed while armed
    a_relay_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == MODE_ARMED))
        else $error("relay driven closed outside armed mode");

    // watchdog start comes with a relay close command and a nonzero window
    a_wd_start: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4]) |->
            (m_tdata[1:0] == MODE_ARMED && m_tdata[3] && m_tdata[2] && m_tdata[29:5] != 25'd0))
        else $error("watchdog start without an armed relay close");

    // nonce clear only on a relay-open command into safe
    a_clear_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[60]) |->
            (m_tdata[1:0] == MODE_SAFE && m_tdata[3] && !m_tdata[2]))
        else $error("nonce clear outside entry to safe");

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind lease_safety_interlock lsi_checker u_lsi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
